// ===== rtl/sst_pkg.sv =====
// ----------------------------------------------------------------------------
// Sorted set table package
// Shared widths, request kinds and status codes for the sorted set table.
// ----------------------------------------------------------------------------
package sst_pkg;

    // Field widths of the request and result transactions.
    localparam int KEY_W    = 31;
    localparam int KIND_W   = 2;
    localparam int POS_W    = 7;
    localparam int STATUS_W = 2;

    // Request kinds. The unused code behaves as a find.
    localparam logic [KIND_W-1:0] KIND_FIND   = 2'd0;
    localparam logic [KIND_W-1:0] KIND_ADD    = 2'd1;
    localparam logic [KIND_W-1:0] KIND_REMOVE = 2'd2;

    // Result status codes.
    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

    // Outcome of one key comparison.
    typedef struct packed {
        logic lt;
        logic eq;
    } t_cmp;

endpackage

// ===== rtl/sst_ram.sv =====
// ----------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module sst_ram #(
    parameter int WIDTH = 31,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port and registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/sst_cmp.sv =====
// ----------------------------------------------------------------------------
// Key comparator
// The shared compare unit: tells whether a stored key is below or equal to
// the requested key.
// ----------------------------------------------------------------------------
module sst_cmp (
    input  logic [sst_pkg::KEY_W-1:0] i_entry,
    input  logic [sst_pkg::KEY_W-1:0] i_key,
    output sst_pkg::t_cmp             o_cmp
);

    // One magnitude compare and one equality compare.
    always_comb begin
        o_cmp.lt = (i_entry < i_key);
        o_cmp.eq = (i_entry == i_key);
    end

endmodule

// ===== rtl/sorted_set_table_top.sv =====
// ----------------------------------------------------------------------------
// Sorted set table
// Keeps up to CAPACITY distinct 31-bit keys in ascending order in one RAM
// and serves find, add and remove requests on them.
//
// Usage: a request transaction (i_kind, i_key) is taken on i_in_valid and
// o_in_ready; one result transaction (o_position, o_present, o_status,
// o_count) leaves on o_out_valid and i_out_ready for every request.
// The block works on one request at a time and drops o_in_ready meanwhile.
// The keys are walked one RAM read per cycle through a single comparator,
// then add and remove move the larger keys one slot per cycle through the
// same read and write port. A find stops its walk at the key's sorted
// position; an add or a remove that changes the set then also moves every
// larger key, so its run grows with the number of keys held. The next request
// can be taken once the result has gone to the output register.
// A finished result sits in an output register; the next request is taken
// while it waits, and only the hand-off of that next result waits for the
// receiver. Reset empties the set at once; the RAM needs no clearing since
// only slots below the count are ever used.
// ----------------------------------------------------------------------------
module sorted_set_table_top #(
    parameter int CAPACITY = 64
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    output logic                         o_in_ready,
    input  logic [sst_pkg::KIND_W-1:0]   i_kind,
    input  logic [sst_pkg::KEY_W-1:0]    i_key,
    output logic                         o_out_valid,
    input  logic                         i_out_ready,
    output logic [sst_pkg::POS_W-1:0]    o_position,
    output logic                         o_present,
    output logic [sst_pkg::STATUS_W-1:0] o_status,
    output logic [sst_pkg::POS_W-1:0]    o_count
);

    localparam int CW = $clog2(CAPACITY + 1);
    localparam int AW = $clog2(CAPACITY);

    // Sequencer states.
    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_SCAN   = 3'd1;
    localparam logic [2:0] S_DECIDE = 3'd2;
    localparam logic [2:0] S_UP     = 3'd3;
    localparam logic [2:0] S_PUT    = 3'd4;
    localparam logic [2:0] S_DOWN   = 3'd5;
    localparam logic [2:0] S_FIN    = 3'd6;

    logic [2:0]                   r_state, n_state;
    logic [sst_pkg::KIND_W-1:0]   r_kind, n_kind;
    logic [sst_pkg::KEY_W-1:0]    r_key, n_key;
    logic [CW-1:0]                r_idx, n_idx;
    logic [CW-1:0]                r_pos, n_pos;
    logic                         r_present, n_present;
    logic [sst_pkg::STATUS_W-1:0] r_status, n_status;
    logic [CW-1:0]                r_held, n_held;

    logic                         r_out_valid, n_out_valid;
    logic [sst_pkg::POS_W-1:0]    r_out_pos, n_out_pos;
    logic                         r_out_present, n_out_present;
    logic [sst_pkg::STATUS_W-1:0] r_out_status, n_out_status;
    logic [sst_pkg::POS_W-1:0]    r_out_count, n_out_count;

    logic                         w_we;
    logic [AW-1:0]                w_waddr;
    logic [sst_pkg::KEY_W-1:0]    w_wdata;
    logic [AW-1:0]                w_raddr;
    logic [sst_pkg::KEY_W-1:0]    w_rdata;
    sst_pkg::t_cmp                w_cmp;
    logic                         w_in_acc;
    logic                         w_out_free;

    // Key storage.
    sst_ram #(
        .WIDTH (sst_pkg::KEY_W),
        .DEPTH (CAPACITY)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    // Shared comparator for the search walk.
    sst_cmp u_cmp (
        .i_entry (w_rdata),
        .i_key   (r_key),
        .o_cmp   (w_cmp)
    );

    assign o_in_ready = (r_state == S_IDLE);
    assign w_in_acc   = i_in_valid && o_in_ready;
    assign w_out_free = !r_out_valid || i_out_ready;

    // Sequencer: search, then for add and remove shift and write, then hand off the result.
    always_comb begin
        n_state       = r_state;
        n_kind        = r_kind;
        n_key         = r_key;
        n_idx         = r_idx;
        n_pos         = r_pos;
        n_present     = r_present;
        n_status      = r_status;
        n_held        = r_held;
        n_out_valid   = r_out_valid && !i_out_ready;
        n_out_pos     = r_out_pos;
        n_out_present = r_out_present;
        n_out_status  = r_out_status;
        n_out_count   = r_out_count;
        w_we          = 1'b0;
        w_waddr       = '0;
        w_wdata       = r_key;
        w_raddr       = '0;

        unique case (r_state)
            S_IDLE: begin
                if (w_in_acc) begin
                    n_kind    = i_kind;
                    n_key     = i_key;
                    n_idx     = '0;
                    n_pos     = '0;
                    n_present = 1'b0;
                    n_status  = sst_pkg::ST_OK;
                    if (r_held == '0) begin
                        n_state = S_DECIDE;
                    end else begin
                        n_state = S_SCAN;
                    end
                end
            end
            S_SCAN: begin
                // The read data holds the key in slot r_idx.
                w_raddr = AW'(r_idx + CW'(1));
                if (w_cmp.lt) begin
                    n_idx = r_idx + CW'(1);
                    if (r_idx + CW'(1) == r_held) begin
                        n_pos   = r_held;
                        n_state = S_DECIDE;
                    end
                end else begin
                    n_pos     = r_idx;
                    n_present = w_cmp.eq;
                    n_state   = S_DECIDE;
                end
            end
            S_DECIDE: begin
                n_state = S_FIN;
                case (r_kind)
                    sst_pkg::KIND_ADD: begin
                        if (r_present) begin
                            n_state = S_FIN;
                        end else if (r_held == CW'(CAPACITY)) begin
                            n_status = sst_pkg::ST_FULL;
                        end else if (r_pos == r_held) begin
                            w_we    = 1'b1;
                            w_waddr = AW'(r_pos);
                            n_held  = r_held + CW'(1);
                        end else begin
                            n_idx   = r_held;
                            w_raddr = AW'(r_held - CW'(1));
                            n_state = S_UP;
                        end
                    end
                    sst_pkg::KIND_REMOVE: begin
                        if (r_held == '0) begin
                            n_status = sst_pkg::ST_EMPTY;
                        end else if (r_present) begin
                            if (r_pos + CW'(1) == r_held) begin
                                n_held = r_held - CW'(1);
                            end else begin
                                n_idx   = r_pos + CW'(1);
                                w_raddr = AW'(r_pos + CW'(1));
                                n_state = S_DOWN;
                            end
                        end
                    end
                    default: begin
                        n_state = S_FIN;
                    end
                endcase
            end
            S_UP: begin
                // Move slot r_idx-1 up into slot r_idx.
                w_we    = 1'b1;
                w_waddr = AW'(r_idx);
                w_wdata = w_rdata;
                w_raddr = AW'(r_idx - CW'(2));
                if (r_idx - CW'(1) == r_pos) begin
                    n_state = S_PUT;
                end else begin
                    n_idx = r_idx - CW'(1);
                end
            end
            S_PUT: begin
                w_we    = 1'b1;
                w_waddr = AW'(r_pos);
                n_held  = r_held + CW'(1);
                n_state = S_FIN;
            end
            S_DOWN: begin
                // Move slot r_idx down into slot r_idx-1.
                w_we    = 1'b1;
                w_waddr = AW'(r_idx - CW'(1));
                w_wdata = w_rdata;
                w_raddr = AW'(r_idx + CW'(1));
                if (r_idx + CW'(1) == r_held) begin
                    n_held  = r_held - CW'(1);
                    n_state = S_FIN;
                end else begin
                    n_idx = r_idx + CW'(1);
                end
            end
            S_FIN: begin
                if (w_out_free) begin
                    n_out_valid   = 1'b1;
                    n_out_pos     = sst_pkg::POS_W'(r_pos);
                    n_out_present = r_present;
                    n_out_status  = r_status;
                    n_out_count   = sst_pkg::POS_W'(r_held);
                    n_state       = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_held      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_held      <= n_held;
            r_out_valid <= n_out_valid;
        end
    end

    // Working and result payload registers.
    always_ff @(posedge i_clk) begin
        r_kind        <= n_kind;
        r_key         <= n_key;
        r_idx         <= n_idx;
        r_pos         <= n_pos;
        r_present     <= n_present;
        r_status      <= n_status;
        r_out_pos     <= n_out_pos;
        r_out_present <= n_out_present;
        r_out_status  <= n_out_status;
        r_out_count   <= n_out_count;
    end

    assign o_out_valid = r_out_valid;
    assign o_position  = r_out_pos;
    assign o_present   = r_out_present;
    assign o_status    = r_out_status;
    assign o_count     = r_out_count;

    // The count never exceeds the capacity.
    a_held_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_held <= CW'(CAPACITY))
        else $error("key count above capacity");

    // A refused add reports a full table.
    a_full_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_status == sst_pkg::ST_FULL)
            |-> (o_count == sst_pkg::POS_W'(CAPACITY) && !o_present))
        else $error("full status without a full table");

    // A remove on an empty set reports position zero and an empty set.
    a_empty_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_status == sst_pkg::ST_EMPTY)
            |-> (o_position == '0 && o_count == '0 && !o_present))
        else $error("empty status with inconsistent result");

    // The search walk never writes the RAM.
    a_scan_no_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN || r_state == S_IDLE || r_state == S_FIN) |-> !w_we)
        else $error("RAM written outside an update step");

endmodule
